// ===== rtl/core/sbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted bag running median: shared package
// Types, constants and status codes used by the cell row and the top level.
// ----------------------------------------------------------------------------
package sbrm_pkg;

  // Store geometry.
  localparam int CAPACITY = 32;
  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = SAMPLE_W + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OUT_W    = MEDIAN_W + 1 + 2 + CNT_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int IN_BYTES_W  = ((SAMPLE_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic [CNT_W-1:0]           count_t;

  // Operation carried with each input item.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic    en;
    op_t     op;
    sample_t value;
  } cell_cmd_t;

  // Per-cell control derived from the occupancy.
  typedef struct packed {
    logic valid;
    logic sel_lo;
    logic sel_hi;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sorted_bag_running_median_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted bag running median: top level
// Keeps a sorted bag of signed samples in a row of cells and reports twice
// the median after every insert or remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_tdata carries the sample, in_tuser the operation
//   (0 insert, 1 remove one copy). Output channel out_*: one result item per
//   input item with twice the median, non-empty flag, status and occupancy.
//   The row of cells updates at the edge that accepts the item; the median
//   is picked from the cells in the following cycle and registered in the
//   output register as soon as that register is free.
//   The median pick reads the cells after their update, so in_tready stays
//   low while a result waits in the pick stage, and no new item is taken.
//   When the receiver stalls, the finished result waits in the output
//   register while one further item can be accepted and applied to the row;
//   its result then waits in the pick stage until the output register frees.
//   Reset empties the bag (occupancy zero); the cell contents are not
//   cleared, since entries beyond the occupancy are never read.
//   An insert into a full bag is dropped with status 1; a remove of a value
//   not present leaves the bag unchanged with status 2.
// ----------------------------------------------------------------------------
module sorted_bag_running_median_unit import sbrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_BYTES_W-1:0]  in_tdata,   // [15:0] value
  input  logic                   in_tuser,   // [0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [16:0] median_x2, [17] nonempty, [19:18] status, [25:20] occupancy
  output logic [OUT_BYTES_W-1:0] out_tdata
);

  count_t  count_r, count_nxt;
  logic    pending_r, pending_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [OUT_BYTES_W-1:0] out_data_r;

  logic      in_acc;
  logic      out_load;
  cell_cmd_t cmd;
  sample_t   in_value;
  op_t       in_op;
  logic      found;
  logic      full;
  median_t   median_x2;

  logic [IDX_W-1:0] mid_hi;
  logic [IDX_W-1:0] mid_lo;
  count_t           count_m1;

  sample_t    [CAPACITY-1:0] entries;
  sample_t    [CAPACITY-1:0] lo_vals;
  sample_t    [CAPACITY-1:0] hi_vals;
  logic       [CAPACITY-1:0] gts;
  logic       [CAPACITY-1:0] eqs;
  cell_ctrl_t [CAPACITY-1:0] ctrls;

  // Handshake.
  assign in_tready  = !pending_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = pending_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Decode the input item.
  assign in_value = in_tdata[SAMPLE_W-1:0];
  assign in_op    = op_t'(in_tuser);
  assign full     = (count_r == count_t'(CAPACITY));
  assign found    = |eqs;

  // Broadcast command: a dropped insert or a missed remove leaves the row.
  always_comb begin
    cmd.op    = in_op;
    cmd.value = in_value;
    if (in_op == OP_INSERT) begin
      cmd.en = in_acc && !full;
    end else begin
      cmd.en = in_acc && found;
    end
  end

  // Middle positions of the current occupancy.
  assign count_m1 = count_r - count_t'(1);
  assign mid_hi   = count_r[CNT_W-1:1];
  assign mid_lo   = count_m1[CNT_W-1:1];

  // Row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sample_t left_entry;
    logic    left_gt;
    sample_t right_entry;

    assign ctrls[i].valid  = (count_t'(i) < count_r);
    assign ctrls[i].sel_hi = (count_r != '0) && (mid_hi == IDX_W'(i));
    assign ctrls[i].sel_lo = (count_r != '0) && (mid_lo == IDX_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_gt    = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sbrm_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .ctrl        (ctrls[i]),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .gt          (gts[i]),
      .eq          (eqs[i]),
      .lo_val      (lo_vals[i]),
      .hi_val      (hi_vals[i])
    );
  end

  // Median of the updated row.
  sbrm_median u_median (
    .lo_vals   (lo_vals),
    .hi_vals   (hi_vals),
    .median_x2 (median_x2)
  );

  // Occupancy, status and pick-stage control.
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      pending_nxt   = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      pending_nxt = 1'b1;
      if (in_op == OP_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          count_nxt  = count_r + count_t'(1);
        end
      end else begin
        if (found) begin
          status_nxt = ST_OK;
          count_nxt  = count_m1;
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_BYTES_W'({count_r, status_r, (count_r != '0), median_x2});
    end
  end

`ifndef SYNTHESIS
  // The bag never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("occupancy above capacity");

  // An accepted item always enters the pick stage.
  a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pending_r)
    else $error("accepted item not pending");

  // An insert into a full bag is flagged and leaves the occupancy alone.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_INSERT && full) |=>
      (status_r == ST_FULL && count_r == count_t'(CAPACITY)))
    else $error("full insert not dropped");

  // While a result waits in the pick stage the occupancy holds.
  a_pending_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && !out_load) |=> $stable(count_r))
    else $error("occupancy moved while pending");
`endif

endmodule

// ===== rtl/core/sbrm_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted bag running median: storage cell
// Holds one entry of the sorted row and shifts toward or away from its
// neighbors when a sample is inserted or removed.
// ----------------------------------------------------------------------------
module sbrm_cell import sbrm_pkg::*; (
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  cell_ctrl_t ctrl,
  input  sample_t    left_entry,
  input  logic       left_gt,
  input  sample_t    right_entry,
  output sample_t    entry,
  output logic       gt,
  output logic       eq,
  output sample_t    lo_val,
  output sample_t    hi_val
);

  sample_t entry_r;
  sample_t entry_nxt;
  logic    ge;

  // Compare against the broadcast sample; an empty cell acts as plus infinity.
  assign gt = !ctrl.valid || (entry_r > cmd.value);
  assign ge = !ctrl.valid || (entry_r >= cmd.value);
  assign eq = ctrl.valid && (entry_r == cmd.value);

  // Contribution to the median pick.
  assign lo_val = ctrl.sel_lo ? entry_r : '0;
  assign hi_val = ctrl.sel_hi ? entry_r : '0;
  assign entry  = entry_r;

  // An insert pushes larger entries one place right; a remove pulls the
  // entries at and beyond the match one place left.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.en) begin
      if (cmd.op == OP_INSERT) begin
        if (gt) begin
          entry_nxt = left_gt ? left_entry : cmd.value;
        end
      end else begin
        if (ge) begin
          entry_nxt = right_entry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/core/sbrm_median.sv =====
// ----------------------------------------------------------------------------
// Sorted bag running median: median pick
// Gathers the two middle entries flagged by the cells and adds them.
// ----------------------------------------------------------------------------
module sbrm_median import sbrm_pkg::*; (
  input  sample_t [CAPACITY-1:0] lo_vals,
  input  sample_t [CAPACITY-1:0] hi_vals,
  output median_t                median_x2
);

  sample_t lo_sel;
  sample_t hi_sel;

  // At most one cell drives each bus, so an OR gathers the selected entry.
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_sel = lo_sel | lo_vals[i];
      hi_sel = hi_sel | hi_vals[i];
    end
  end

  // For an odd count both picks are the same middle entry.
  assign median_x2 = median_t'(lo_sel) + median_t'(hi_sel);

endmodule
